@@ hdl/iso_ms_pkg.sv @@
// Shared types for the timestamp to epoch milliseconds block.
`timescale 1ns / 1ps
package iso_ms_pkg;

  // One input beat: a character and its end-of-string mark.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } in_beat_t;

  // One output beat.
  typedef struct packed {
    logic signed [48:0] epoch_ms;
    logic               format_ok;
  } out_beat_t;

  // Fields of one parsed timestamp, handed from the parser to the arithmetic.
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  fraction;
    logic        off_neg;
    logic [6:0]  off_hours;
    logic [6:0]  off_minutes;
    logic        off_hours_apply;
    logic        off_minutes_apply;
    logic        ok;
  } fields_t;

  // Arithmetic steps, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERA,
    OP_YOE,
    OP_DOE,
    OP_DAYS,
    OP_HOUR,
    OP_MIN,
    OP_SEC,
    OP_MS,
    OP_OFF
  } calc_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     parse_step;
    calc_op_t op;
  } ctrl_cmd_t;

endpackage

@@ hdl/iso_ms_parse.sv @@
// Character parser: splits the timestamp text into numeric fields.
`timescale 1ns / 1ps
module iso_ms_parse (
  input  logic                clk,
  input  logic                rst,
  input  iso_ms_pkg::in_beat_t in_data,
  input  logic                step,
  output iso_ms_pkg::fields_t fields
);
  import iso_ms_pkg::*;

  typedef enum logic [8:0] {
    PH_LEAD     = 9'b000000001,
    PH_FIXED    = 9'b000000010,
    PH_POS19    = 9'b000000100,
    PH_FRAC     = 9'b000001000,
    PH_OFF_H    = 9'b000010000,
    PH_OFF_SEP  = 9'b000100000,
    PH_OFF_M    = 9'b001000000,
    PH_OFF_DONE = 9'b010000000,
    PH_DONE     = 9'b100000000
  } phase_t;

  localparam logic [1:0] FM_SKIP = 2'd0;
  localparam logic [1:0] FM_TAKE = 2'd1;
  localparam logic [1:0] FM_STOP = 2'd2;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UP_T   = 8'h54;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  typedef struct packed {
    logic [13:0] acc;
    logic [1:0]  mode;
  } fld_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] count;
    logic [1:0] mode;
    logic [6:0] hacc;
    logic [6:0] macc;
  } ost_t;

  function automatic logic is_trim(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Skip leading blanks, take leading digits, stop at anything else.
  function automatic fld_t field_char(input logic [13:0] acc, input logic [1:0] mode,
                                      input logic [7:0] c);
    fld_t r;
    r.acc  = acc;
    r.mode = mode;
    case (mode)
      FM_SKIP: begin
        if (!(is_trim(c) || c == CH_VT || c == CH_FF)) begin
          if (is_digit(c)) begin
            r.acc  = {10'd0, c[3:0]};
            r.mode = FM_TAKE;
          end else begin
            r.mode = FM_STOP;
          end
        end
      end
      FM_TAKE: begin
        if (is_digit(c)) begin
          r.acc = 14'(acc * 14'd10 + {10'd0, c[3:0]});
        end else begin
          r.mode = FM_STOP;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Advance the offset subfields by one character.
  function automatic ost_t offset_char(input ost_t s, input logic [7:0] c);
    ost_t r;
    fld_t f;
    r = s;
    f = '0;
    case (s.phase)
      PH_OFF_H: begin
        f      = field_char({7'd0, s.hacc}, s.mode, c);
        r.hacc = f.acc[6:0];
        r.mode = f.mode;
        if (s.count >= 3'd1) begin
          r.phase = PH_OFF_SEP;
          r.count = 3'd0;
        end else begin
          r.count = s.count + 3'd1;
        end
      end
      PH_OFF_SEP: begin
        r.mode  = FM_SKIP;
        r.phase = PH_OFF_M;
        r.count = 3'd0;
        if (c != CH_COLON) begin
          f      = field_char({7'd0, s.macc}, FM_SKIP, c);
          r.macc = f.acc[6:0];
          r.mode = f.mode;
          r.count = 3'd1;
        end
      end
      PH_OFF_M: begin
        f      = field_char({7'd0, s.macc}, s.mode, c);
        r.macc = f.acc[6:0];
        r.mode = f.mode;
        r.count = s.count + 3'd1;
        if (s.count >= 3'd1) begin
          r.phase = PH_OFF_DONE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  phase_t      phase, phase_next;
  logic [5:0]  bpos, bpos_next;
  logic [5:0]  trail, trail_next;
  logic [13:0] year, year_next;
  logic [6:0]  month, month_next;
  logic [6:0]  day, day_next;
  logic [6:0]  hour, hour_next;
  logic [6:0]  minute, minute_next;
  logic [6:0]  second, second_next;
  logic [9:0]  frac, frac_next;
  logic [1:0]  fcnt, fcnt_next;
  logic        neg, neg_next;
  logic [6:0]  oh, oh_next;
  logic [6:0]  om, om_next;
  logic [2:0]  ocnt, ocnt_next;
  logic        err, err_next;
  logic [1:0]  mode, mode_next;
  phase_t      spec_phase, spec_phase_next;
  logic [2:0]  spec_cnt, spec_cnt_next;
  logic [1:0]  spec_mode, spec_mode_next;

  logic [7:0]  c;
  logic        ws;
  logic [6:0]  pos;
  logic        in_body;
  logic        in_off;
  logic        spec_hold;
  fld_t        f;
  ost_t        os;

  assign c  = in_data.char_byte;
  assign ws = is_trim(c);

  // Compute the parser state after this character.
  always_comb begin
    phase_next = phase;  bpos_next = bpos;     trail_next = trail;
    year_next = year;    month_next = month;   day_next = day;
    hour_next = hour;    minute_next = minute; second_next = second;
    frac_next = frac;    fcnt_next = fcnt;     neg_next = neg;
    oh_next = oh;        om_next = om;         ocnt_next = ocnt;
    err_next = err;      mode_next = mode;
    spec_phase_next = spec_phase; spec_cnt_next = spec_cnt; spec_mode_next = spec_mode;
    spec_hold = 1'b0;
    f  = '0;
    os = '0;
    pos = 7'(bpos) + 7'(trail);

    if (phase == PH_LEAD && !ws) begin
      phase_next = PH_FIXED;
      mode_next  = FM_SKIP;
    end
    in_body = (phase_next == PH_FIXED) || (phase_next == PH_POS19) || (phase_next == PH_FRAC);
    in_off  = (phase_next == PH_OFF_H) || (phase_next == PH_OFF_SEP) ||
              (phase_next == PH_OFF_M);

    if (phase_next != PH_LEAD) begin
      if (!ws) begin
        bpos_next  = (pos >= 7'd63) ? 6'd63 : 6'(pos + 7'd1);
        trail_next = 6'd0;
      end else if (trail != 6'd63) begin
        trail_next = trail + 6'd1;
      end

      if (in_body) begin
        case (phase_next)
          PH_FIXED: begin
            if (pos == 7'd4 || pos == 7'd7) begin
              if (c != CH_DASH) err_next = 1'b1;
              mode_next = FM_SKIP;
            end else if (pos == 7'd10) begin
              if (c != CH_UP_T && c != CH_LOW_T && c != CH_SPACE) err_next = 1'b1;
              mode_next = FM_SKIP;
            end else if (pos == 7'd13 || pos == 7'd16) begin
              if (c != CH_COLON) err_next = 1'b1;
              mode_next = FM_SKIP;
            end else if (pos < 7'd4) begin
              f = field_char(year, mode_next, c);
              year_next = f.acc;
              mode_next = f.mode;
            end else if (pos < 7'd7) begin
              f = field_char({7'd0, month}, mode_next, c);
              month_next = f.acc[6:0];
              mode_next  = f.mode;
            end else if (pos < 7'd10) begin
              f = field_char({7'd0, day}, mode_next, c);
              day_next  = f.acc[6:0];
              mode_next = f.mode;
            end else if (pos < 7'd13) begin
              f = field_char({7'd0, hour}, mode_next, c);
              hour_next = f.acc[6:0];
              mode_next = f.mode;
            end else if (pos < 7'd16) begin
              f = field_char({7'd0, minute}, mode_next, c);
              minute_next = f.acc[6:0];
              mode_next   = f.mode;
            end else begin
              f = field_char({7'd0, second}, mode_next, c);
              second_next = f.acc[6:0];
              mode_next   = f.mode;
            end
            if (pos >= 7'd18) phase_next = PH_POS19;
          end
          PH_POS19: begin
            if (c == CH_DOT || c == CH_COMMA) begin
              phase_next = PH_FRAC;
              fcnt_next  = 2'd0;
            end else if (c == CH_PLUS || c == CH_DASH) begin
              phase_next = PH_OFF_H;
              neg_next   = (c == CH_DASH);
              ocnt_next  = 3'd0;
              mode_next  = FM_SKIP;
            end else begin
              phase_next = PH_DONE;
            end
          end
          default: begin
            // Fraction digits: weight 100, 10, 1, then ignore the rest.
            if (is_digit(c)) begin
              if (fcnt != 2'd3) begin
                case (fcnt)
                  2'd0:    frac_next = frac + 10'(c[3:0]) * 10'd100;
                  2'd1:    frac_next = frac + 10'(c[3:0]) * 10'd10;
                  default: frac_next = frac + 10'(c[3:0]);
                endcase
                fcnt_next = fcnt + 2'd1;
              end
            end else if (c == CH_PLUS || c == CH_DASH) begin
              phase_next = PH_OFF_H;
              neg_next   = (c == CH_DASH);
              ocnt_next  = 3'd0;
              mode_next  = FM_SKIP;
            end else begin
              phase_next = PH_DONE;
            end
          end
        endcase
      end else if (in_off) begin
        // Blanks advance only a tentative copy, committed by the next non-blank.
        os = '{phase: spec_phase, count: spec_cnt, mode: spec_mode, hacc: oh, macc: om};
        if (ws) begin
          os = offset_char(os, CH_SPACE);
          spec_phase_next = os.phase;
          spec_cnt_next   = os.count;
          spec_mode_next  = os.mode;
          spec_hold       = 1'b1;
        end else begin
          os = offset_char(os, c);
          phase_next = os.phase;
          ocnt_next  = os.count;
          mode_next  = os.mode;
          oh_next    = os.hacc;
          om_next    = os.macc;
        end
      end
    end

    if (!spec_hold) begin
      spec_phase_next = phase_next;
      spec_cnt_next   = ocnt_next;
      spec_mode_next  = mode_next;
    end
  end

  // Hold state between beats; clear after the last beat of a string.
  always_ff @(posedge clk) begin
    if (rst || (step && in_data.last_byte)) begin
      phase <= PH_LEAD;  bpos <= '0;   trail <= '0;
      year <= '0;  month <= '0;  day <= '0;  hour <= '0;  minute <= '0;  second <= '0;
      frac <= '0;  fcnt <= '0;   neg <= 1'b0;  oh <= '0;  om <= '0;  ocnt <= '0;
      err <= 1'b0; mode <= FM_SKIP;
      spec_phase <= PH_LEAD;  spec_cnt <= '0;  spec_mode <= FM_SKIP;
    end else if (step) begin
      phase <= phase_next;  bpos <= bpos_next;  trail <= trail_next;
      year <= year_next;  month <= month_next;  day <= day_next;
      hour <= hour_next;  minute <= minute_next;  second <= second_next;
      frac <= frac_next;  fcnt <= fcnt_next;  neg <= neg_next;
      oh <= oh_next;  om <= om_next;  ocnt <= ocnt_next;
      err <= err_next;  mode <= mode_next;
      spec_phase <= spec_phase_next;  spec_cnt <= spec_cnt_next;
      spec_mode <= spec_mode_next;
    end
  end

  // Present the fields as they stand after the current beat.
  always_comb begin
    fields.year              = year_next;
    fields.month             = month_next;
    fields.day               = day_next;
    fields.hour              = hour_next;
    fields.minute            = minute_next;
    fields.second            = second_next;
    fields.fraction          = frac_next;
    fields.off_neg           = neg_next;
    fields.off_hours         = oh_next;
    fields.off_minutes       = om_next;
    fields.off_hours_apply   = phase_next inside {PH_OFF_SEP, PH_OFF_M, PH_OFF_DONE};
    fields.off_minutes_apply = (phase_next == PH_OFF_DONE);
    fields.ok = !err_next && (bpos_next >= 6'd19) &&
                (month_next >= 7'd1) && (month_next <= 7'd12) &&
                (day_next >= 7'd1) && (day_next <= 7'd31);
  end

endmodule

@@ hdl/iso_ms_calc.sv @@
// Arithmetic datapath: civil date and time to epoch milliseconds, one step a cycle.
`timescale 1ns / 1ps
module iso_ms_calc (
  input  logic                  clk,
  input  iso_ms_pkg::ctrl_cmd_t cmd,
  input  iso_ms_pkg::fields_t   fields,
  output iso_ms_pkg::out_beat_t out_data
);
  import iso_ms_pkg::*;

  // Days from March 1 to the first of each month.
  function automatic logic [8:0] month_base(input logic [6:0] m);
    case (m)
      7'd3:    return 9'd0;
      7'd4:    return 9'd31;
      7'd5:    return 9'd61;
      7'd6:    return 9'd92;
      7'd7:    return 9'd122;
      7'd8:    return 9'd153;
      7'd9:    return 9'd184;
      7'd10:   return 9'd214;
      7'd11:   return 9'd245;
      7'd12:   return 9'd275;
      7'd1:    return 9'd306;
      7'd2:    return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

  fields_t            snap;
  logic signed [14:0] y;
  logic signed [5:0]  era;
  logic [8:0]         yoe;
  logic [17:0]        doe;
  logic [12:0]        offmin;
  logic [28:0]        shift;
  logic signed [48:0] acc;

  logic [27:0]        era_prod;
  logic signed [15:0] yoe_w;
  logic [1:0]         cent;
  logic [8:0]         doy;
  logic signed [48:0] shift_s;

  // y / 400 by reciprocal; exact for four-digit years.
  assign era_prod = 28'(y[13:0]) * 28'd5243;
  assign yoe_w    = 16'(y) - 16'(era) * 16'sd400;
  assign cent     = (yoe >= 9'd300) ? 2'd3 : (yoe >= 9'd200) ? 2'd2 :
                    (yoe >= 9'd100) ? 2'd1 : 2'd0;
  assign doy      = 9'(month_base(snap.month) + 9'(snap.day) - 9'd1);
  assign shift_s  = 49'($signed({1'b0, shift}));

  // Run one step of the day and millisecond arithmetic.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        snap <= fields;
        y    <= $signed({1'b0, fields.year}) - ((fields.month <= 7'd2) ? 15'sd1 : 15'sd0);
      end
      OP_ERA: begin
        era    <= y[14] ? -6'sd1 : $signed(6'(era_prod >> 21));
        offmin <= snap.off_hours_apply ?
                  13'(13'(snap.off_hours) * 13'd60 +
                      (snap.off_minutes_apply ? 13'(snap.off_minutes) : 13'd0)) : 13'd0;
      end
      OP_YOE: begin
        yoe   <= yoe_w[8:0];
        shift <= 29'(offmin) * 29'd60000;
      end
      OP_DOE: doe <= 18'(yoe) * 18'd365 + 18'(yoe >> 2) - 18'(cent) + 18'(doy);
      OP_DAYS: acc <= 49'(era) * 49'sd146097 + 49'($signed({1'b0, doe})) - 49'sd719468;
      OP_HOUR: acc <= acc * 49'sd24 + 49'($signed({1'b0, snap.hour}));
      OP_MIN:  acc <= acc * 49'sd60 + 49'($signed({1'b0, snap.minute}));
      OP_SEC:  acc <= acc * 49'sd60 + 49'($signed({1'b0, snap.second}));
      OP_MS:   acc <= acc * 49'sd1000 + 49'($signed({1'b0, snap.fraction}));
      OP_OFF: begin
        if (!snap.ok) begin
          acc <= '0;
        end else if (snap.off_neg) begin
          acc <= acc + shift_s;
        end else begin
          acc <= acc - shift_s;
        end
      end
      default: ;
    endcase
  end

  assign out_data.epoch_ms  = acc;
  assign out_data.format_ok = snap.ok;

endmodule

@@ hdl/iso_ms_ctrl.sv @@
// Controller: accepts characters, then sequences the arithmetic and the output beat.
`timescale 1ns / 1ps
module iso_ms_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_last,
  input  logic                  out_ready,
  output logic                  in_ready,
  output logic                  out_valid,
  output iso_ms_pkg::ctrl_cmd_t cmd
);
  import iso_ms_pkg::*;

  typedef enum logic [10:0] {
    S_PARSE = 11'b00000000001,
    S_ERA   = 11'b00000000010,
    S_YOE   = 11'b00000000100,
    S_DOE   = 11'b00000001000,
    S_DAYS  = 11'b00000010000,
    S_HOUR  = 11'b00000100000,
    S_MIN   = 11'b00001000000,
    S_SEC   = 11'b00010000000,
    S_MS    = 11'b00100000000,
    S_OFF   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready  = (state == S_PARSE);
  assign out_valid = (state == S_OUT);
  assign accept    = in_valid && in_ready;

  // Pick the next step and the command for the datapath.
  always_comb begin
    state_next     = state;
    cmd.parse_step = accept;
    cmd.op         = OP_NONE;
    case (state)
      S_PARSE: begin
        if (accept && in_last) begin
          cmd.op     = OP_LOAD;
          state_next = S_ERA;
        end
      end
      S_ERA:  begin cmd.op = OP_ERA;  state_next = S_YOE;  end
      S_YOE:  begin cmd.op = OP_YOE;  state_next = S_DOE;  end
      S_DOE:  begin cmd.op = OP_DOE;  state_next = S_DAYS; end
      S_DAYS: begin cmd.op = OP_DAYS; state_next = S_HOUR; end
      S_HOUR: begin cmd.op = OP_HOUR; state_next = S_MIN;  end
      S_MIN:  begin cmd.op = OP_MIN;  state_next = S_SEC;  end
      S_SEC:  begin cmd.op = OP_SEC;  state_next = S_MS;   end
      S_MS:   begin cmd.op = OP_MS;   state_next = S_OFF;  end
      S_OFF:  begin cmd.op = OP_OFF;  state_next = S_OUT;  end
      S_OUT: begin
        if (out_ready) state_next = S_PARSE;
      end
      default: state_next = S_PARSE;
    endcase
  end

  // Advance the state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PARSE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/iso8601_timestamp_to_epoch_ms.sv @@
// Top level: ISO 8601 timestamp text to UTC epoch milliseconds.
// The result beat becomes valid after the beat marked last is taken and the nine arithmetic steps have run.
// Throughput: one character per cycle while input is accepted; between strings the block
//   waits out the nine arithmetic steps and the output beat before it takes a new string.
// Input is not taken while the arithmetic runs or the result waits.
// Reset (rst, synchronous) returns the parser to leading whitespace and the controller to idle.
`timescale 1ns / 1ps
module iso8601_timestamp_to_epoch_ms (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  iso_ms_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output iso_ms_pkg::out_beat_t out_data
);
  import iso_ms_pkg::*;

  ctrl_cmd_t cmd;
  fields_t   fields;

  iso_ms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last_byte),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  iso_ms_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .in_data (in_data),
    .step    (cmd.parse_step),
    .fields  (fields)
  );

  iso_ms_calc u_calc (
    .clk      (clk),
    .cmd      (cmd),
    .fields   (fields),
    .out_data (out_data)
  );

  // No input beat is taken while a result is pending.
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // The last character starts the arithmetic and blocks input.
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.last_byte) |=> (!in_ready && !out_valid))
    else $error("last beat did not start arithmetic");

  // Taking the result reopens the input.
  a_out_reopens: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> in_ready) else $error("input not reopened");

  // A malformed timestamp reports zero.
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.format_ok) |-> (out_data.epoch_ms == '0))
    else $error("invalid result not zero");

endmodule
